// ----- hw/rtl/lcsr_pkg.sv -----
// Shared constants, codes and bundle types of the longest common substring run unit.
package lcsr_pkg;

  // Needle store depth and haystack limit
  localparam int NEEDLE_BYTES  = 64;
  localparam int HAY_BYTES_MAX = 1048576;

  // Derived widths
  localparam int NIDX_W = $clog2(NEEDLE_BYTES);
  localparam int LEN_W  = $clog2(NEEDLE_BYTES + 1);
  localparam int POS_W  = $clog2(HAY_BYTES_MAX);
  localparam int HPOS_W = POS_W + 1;
  localparam int SLOT_W = POS_W + 1;
  localparam int BYTE_W = 8;
  localparam int SBYT_W = 8;

  // Stream port widths
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEEDLE_LEN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_BYTES = 1'b1;

  // Item kinds carried on tuser
  typedef enum logic [S_USER_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_HAY    = 2'd1,
    MODE_FINISH = 2'd2
  } lcsr_mode_e;

  // Payload of one haystack byte travelling along the cell row
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;  // haystack byte
    logic [LEN_W-1:0]  prev;       // previous cell's counter before this byte
    logic [LEN_W-1:0]  cap;        // run limit from the position in the region
    logic [LEN_W-1:0]  nl;         // effective needle length
    logic [LEN_W-1:0]  cand_len;   // longest run seen so far for this byte
    logic [NIDX_W-1:0] cand_ns;    // its needle start
    logic [POS_W-1:0]  pos;        // position in haystack or slot
    logic [POS_W-1:0]  slot;       // slot counter
  } lcsr_wave_t;

  // Broadcast control from the front end to every cell
  typedef struct packed {
    logic              needle_we;
    logic [NIDX_W-1:0] needle_idx;
    logic [BYTE_W-1:0] needle_byte;
    logic              clear;
  } lcsr_ctrl_t;

  // Best run held so far
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  hs;
    logic [NIDX_W-1:0] ns;
    logic [SLOT_W-1:0] slot;
  } lcsr_best_t;

endpackage

// ----- hw/rtl/lcsr_cell.sv -----
// One cell of the row: a needle byte, its run counter and the travelling byte stage.
module lcsr_cell
  import lcsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NIDX_W-1:0] cell_idx_i,
  input  lcsr_ctrl_t        ctrl_i,
  input  logic              valid_i,
  input  lcsr_wave_t        wave_i,
  output logic              valid_o,
  output lcsr_wave_t        wave_o
);

  logic [BYTE_W-1:0] needle_q;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              valid_q;
  lcsr_wave_t        wave_q, wave_d;
  logic [LEN_W-1:0]  prev_inc;
  logic [LEN_W-1:0]  run_c;
  logic [LEN_W-1:0]  c;
  logic [LEN_W-1:0]  ns_full;
  logic              active;

  // Hold the needle byte; written by index, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.needle_we && (ctrl_i.needle_idx == cell_idx_i)) begin
      needle_q <= ctrl_i.needle_byte;
    end
  end

  // Extend the run handed on by the previous cell, limited by the region start
  always_comb begin
    prev_inc = wave_i.prev + LEN_W'(1);
    run_c    = (prev_inc < wave_i.cap) ? prev_inc : wave_i.cap;
    active   = {1'b0, cell_idx_i} < wave_i.nl;
    c        = (active && (wave_i.data_byte == needle_q)) ? run_c : '0;
    ns_full  = LEN_W'({1'b0, cell_idx_i}) + LEN_W'(1) - c;
  end

  // Hand on the old counter and keep the earliest longest candidate
  always_comb begin
    wave_d      = wave_i;
    wave_d.prev = cnt_q;
    if (c > wave_i.cand_len) begin
      wave_d.cand_len = c;
      wave_d.cand_ns  = ns_full[NIDX_W-1:0];
    end
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (valid_i) begin
      cnt_d = c;
    end
  end

  // Run counter and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      wave_q <= wave_d;
    end
  end

  assign valid_o = valid_q;
  assign wave_o  = wave_q;

endmodule

// ----- hw/rtl/lcsr_best.sv -----
// Best-run tracker at the end of the cell row.
module lcsr_best
  import lcsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       valid_i,
  input  lcsr_wave_t wave_i,
  output lcsr_best_t best_o
);

  lcsr_best_t        best_q, best_d;
  logic [POS_W-1:0]  hs;
  logic [SLOT_W-1:0] slot_ext;
  logic              better;

  // Compare the byte's best candidate with the run held so far
  always_comb begin
    hs       = wave_i.pos + POS_W'(1) - POS_W'(wave_i.cand_len);
    slot_ext = {1'b0, wave_i.slot};
    better   = (wave_i.cand_len > best_q.len) ||
               ((wave_i.cand_len == best_q.len) &&
                ((slot_ext < best_q.slot) ||
                 ((slot_ext == best_q.slot) &&
                  ((hs < best_q.hs) ||
                   ((hs == best_q.hs) && (wave_i.cand_ns < best_q.ns))))));
    best_d = best_q;
    if (clear_i) begin
      best_d.len  = '0;
      best_d.hs   = '0;
      best_d.ns   = '0;
      best_d.slot = '1;
    end else if (valid_i && (wave_i.cand_len != '0) && better) begin
      best_d.len  = wave_i.cand_len;
      best_d.hs   = hs;
      best_d.ns   = wave_i.cand_ns;
      best_d.slot = slot_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q.len  <= '0;
      best_q.hs   <= '0;
      best_q.ns   <= '0;
      best_q.slot <= '1;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

// ----- hw/rtl/longest_common_substring_run_unit.sv -----
// Top level: front end, systolic cell row, best tracker and result register.
//
// Load the needle with MODE_LOAD items, stream the haystack with MODE_HAY
// items, then send a MODE_FINISH item to get one result and start a fresh
// search. Haystack bytes are taken one per cycle: each byte walks the row of
// NEEDLE_BYTES cells, one cell per cycle, and its effect on the best run is
// registered in the best tracker once it leaves the last cell. Needle loads
// wait until the row has drained, and the finish item also waits for a free
// result register. Configuration writes take effect on the next haystack
// byte; write them with the row drained.
module longest_common_substring_run_unit
  import lcsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,  // needle_index[5:0], data_byte[13:6], zero
  input  logic [S_USER_W-1:0]   s_axis_tuser,  // mode[1:0]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_DATA_W-1:0]   m_axis_tdata   // run_length[6:0], hay_offset[26:7],
                                               // needle_offset[32:27], slot_index[53:33],
                                               // hay_overflow[54], zero[55]
);

  // Configuration registers
  logic [LEN_W-1:0]  needle_len_q;
  logic [SBYT_W-1:0] slot_bytes_q;

  // Stream state
  logic [HPOS_W-1:0] hay_pos_q, hay_pos_d;
  logic [SBYT_W-1:0] slot_pos_q, slot_pos_d;
  logic [POS_W-1:0]  slot_cnt_q, slot_cnt_d;
  logic              ovf_q, ovf_d;

  // Result register
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  // Front end
  lcsr_mode_e        mode;
  logic [NIDX_W-1:0] in_idx;
  logic [BYTE_W-1:0] in_byte;
  logic              s_fire, hay_fire, load_fire, fin_fire;
  logic              busy, out_free;
  logic              slots, hay_full, wrap;
  logic [SBYT_W-1:0] slot_pos_eff;
  logic [POS_W-1:0]  slot_cnt_eff;
  logic [POS_W-1:0]  pos;
  logic [LEN_W-1:0]  nl_eff;
  logic              inject;
  lcsr_ctrl_t        ctrl;
  lcsr_best_t        best;

  // Cell row links: index 0 is the front end, index i+1 the output of cell i
  logic       row_valid [NEEDLE_BYTES+1];
  lcsr_wave_t row_wave  [NEEDLE_BYTES+1];
  logic [NEEDLE_BYTES-1:0] cell_valid;

  assign mode    = lcsr_mode_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[NIDX_W-1:0];
  assign in_byte = s_axis_tdata[NIDX_W +: BYTE_W];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q <= LEN_W'(32);
      slot_bytes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_NEEDLE_LEN: needle_len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_SLOT_BYTES: slot_bytes_q <= cfg_wdata_i[SBYT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Row is busy while any cell holds a byte in flight
  always_comb begin
    for (int i = 0; i < NEEDLE_BYTES; i++) begin
      cell_valid[i] = row_valid[i+1];
    end
  end
  assign busy     = |cell_valid;
  assign out_free = !m_valid_q || m_axis_tready;

  // Accept haystack and unused items always; hold loads until the row drains, finish also for a free result
  always_comb begin
    unique case (mode)
      MODE_LOAD:   s_axis_tready = !busy;
      MODE_HAY:    s_axis_tready = 1'b1;
      MODE_FINISH: s_axis_tready = !busy && out_free;
      default:     s_axis_tready = 1'b1;
    endcase
  end

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign hay_fire  = s_fire && (mode == MODE_HAY);
  assign load_fire = s_fire && (mode == MODE_LOAD);
  assign fin_fire  = s_fire && (mode == MODE_FINISH);

  // Work out the position of the incoming byte in its region
  always_comb begin
    slots        = slot_bytes_q != '0;
    hay_full     = ovf_q || (hay_pos_q >= HPOS_W'(HAY_BYTES_MAX));
    wrap         = slots && (slot_pos_q >= slot_bytes_q);
    slot_pos_eff = wrap ? '0 : slot_pos_q;
    slot_cnt_eff = wrap ? slot_cnt_q + POS_W'(1) : slot_cnt_q;
    pos          = slots ? POS_W'(slot_pos_eff) : hay_pos_q[POS_W-1:0];
    nl_eff       = (needle_len_q > LEN_W'(NEEDLE_BYTES)) ? LEN_W'(NEEDLE_BYTES)
                                                         : needle_len_q;
    inject       = hay_fire && !hay_full;
  end

  // Build the item entering cell 0
  always_comb begin
    row_valid[0]          = inject;
    row_wave[0].data_byte = in_byte;
    row_wave[0].prev      = '0;
    row_wave[0].cap       = (pos < POS_W'(NEEDLE_BYTES))
                            ? LEN_W'(pos[NIDX_W-1:0]) + LEN_W'(1)
                            : LEN_W'(NEEDLE_BYTES);
    row_wave[0].nl        = nl_eff;
    row_wave[0].cand_len  = '0;
    row_wave[0].cand_ns   = '0;
    row_wave[0].pos       = pos;
    row_wave[0].slot      = slot_cnt_eff;
  end

  // Broadcast needle writes and the clear on finish
  always_comb begin
    ctrl.needle_we   = load_fire;
    ctrl.needle_idx  = in_idx;
    ctrl.needle_byte = in_byte;
    ctrl.clear       = fin_fire;
  end

  // Advance haystack, slot and overflow state
  always_comb begin
    hay_pos_d  = hay_pos_q;
    slot_pos_d = slot_pos_q;
    slot_cnt_d = slot_cnt_q;
    ovf_d      = ovf_q;
    if (fin_fire) begin
      hay_pos_d  = '0;
      slot_pos_d = '0;
      slot_cnt_d = '0;
      ovf_d      = 1'b0;
    end else if (hay_fire) begin
      if (hay_full) begin
        ovf_d = 1'b1;
      end else begin
        hay_pos_d  = hay_pos_q + HPOS_W'(1);
        slot_cnt_d = slot_cnt_eff;
        if (slots) begin
          slot_pos_d = slot_pos_eff + SBYT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hay_pos_q  <= '0;
      slot_pos_q <= '0;
      slot_cnt_q <= '0;
      ovf_q      <= 1'b0;
    end else begin
      hay_pos_q  <= hay_pos_d;
      slot_pos_q <= slot_pos_d;
      slot_cnt_q <= slot_cnt_d;
      ovf_q      <= ovf_d;
    end
  end

  // Row of cells
  for (genvar g = 0; g < NEEDLE_BYTES; g++) begin : g_cell
    lcsr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (NIDX_W'(g)),
      .ctrl_i     (ctrl),
      .valid_i    (row_valid[g]),
      .wave_i     (row_wave[g]),
      .valid_o    (row_valid[g+1]),
      .wave_o     (row_wave[g+1])
    );
  end

  // Best run at the end of the row
  lcsr_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (fin_fire),
    .valid_i (row_valid[NEEDLE_BYTES]),
    .wave_i  (row_wave[NEEDLE_BYTES]),
    .best_o  (best)
  );

  // Pack the result item
  always_comb begin
    logic              found;
    logic [SLOT_W-1:0] slot_out;
    found    = best.len != '0;
    slot_out = (found && slots) ? best.slot : '1;
    m_data_d = {1'b0,
                ovf_q,
                slot_out,
                found ? best.ns : '0,
                found ? best.hs : '0,
                best.len};
    m_valid_d = m_valid_q;
    if (fin_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  // A finish item always yields a result in the next cycle
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> m_axis_tvalid)
    else $error("finish item gave no result");

  // Needle bytes are never rewritten under a byte in flight
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |-> !busy)
    else $error("needle written while row busy");

  // Reported run never exceeds the needle store
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[LEN_W-1:0] <= LEN_W'(NEEDLE_BYTES)))
    else $error("run length out of range");

  // Overflow stays set until the next finish
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !fin_fire) |=> ovf_q)
    else $error("overflow flag dropped");
`endif

endmodule

// ----- verif/lcsr_result_checker.sv -----
// Checker for the longest common substring run unit: predicts each search result and compares.
`timescale 1ns / 1ps

module lcsr_result_checker
  import lcsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,  // needle_index[5:0], data_byte[13:6], zero
  input  logic [S_USER_W-1:0]   s_axis_tuser,  // mode[1:0]
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_DATA_W-1:0]   m_axis_tdata,  // run_length[6:0], hay_offset[26:7],
                                               // needle_offset[32:27], slot_index[53:33],
                                               // hay_overflow[54], zero[55]
  output int                    awaited_o,
  output int                    mismatches_o
);

  // One search result, last field in the lowest bits as on the result port
  typedef struct packed {
    logic              overflow;
    logic [SLOT_W-1:0] slot;
    logic [NIDX_W-1:0] needle_start;
    logic [POS_W-1:0]  hay_start;
    logic [LEN_W-1:0]  run_len;
  } lcs_result_t;

  // Register copies
  logic [LEN_W-1:0]  needle_len_q;
  logic [SBYT_W-1:0] slot_bytes_q;

  // Search state
  logic [BYTE_W-1:0] needle_q [NEEDLE_BYTES];
  logic [LEN_W-1:0]  run_cnt  [NEEDLE_BYTES];
  logic [LEN_W-1:0]  best_len;
  logic [POS_W-1:0]  best_hs;
  logic [NIDX_W-1:0] best_ns;
  logic [SLOT_W-1:0] best_slot;
  logic [HPOS_W-1:0] hay_pos;
  logic [SBYT_W-1:0] slot_pos;
  logic [POS_W-1:0]  slot_cnt;
  logic              hay_overflow;
  int                live_span;  // counters at or above this index are known zero

  lcs_result_t awaited_results [$];
  int          mismatches;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] search result %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Drop the stream state, keep the needle and the registers
  function automatic void restart_search();
    int j;
    for (j = 0; j < live_span; j++) run_cnt[j] = '0;
    live_span    = 0;
    best_len     = '0;
    best_hs      = '0;
    best_ns      = '0;
    best_slot    = '1;
    hay_pos      = '0;
    slot_pos     = '0;
    slot_cnt     = '0;
    hay_overflow = 1'b0;
  endfunction

  // Advance the counter row by one haystack byte and update the best run
  function automatic void absorb_hay_byte(input logic [BYTE_W-1:0] b);
    int  nl, pos, prev, old, c, hs, ns, j;
    bit  slots, better;
    nl    = (needle_len_q > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len_q);
    slots = (slot_bytes_q != 0);
    if (hay_overflow || hay_pos >= HAY_BYTES_MAX) begin
      hay_overflow = 1'b1;
      return;
    end
    if (slots && slot_pos >= slot_bytes_q) begin
      slot_pos = '0;
      slot_cnt = slot_cnt + 1'b1;
    end
    pos  = slots ? int'(slot_pos) : int'(hay_pos);
    prev = 0;
    for (j = 0; j < nl; j++) begin
      old = run_cnt[j];
      c   = 0;
      // a run never reaches back past the start of the region
      if (b == needle_q[j]) begin
        c = prev + 1;
        if (c > pos + 1) c = pos + 1;
      end
      prev       = old;
      run_cnt[j] = LEN_W'(c);
      if (c != 0) begin
        hs = pos + 1 - c;
        ns = j + 1 - c;
        better = c > best_len ||
                 (c == best_len &&
                  (slot_cnt < best_slot ||
                   (slot_cnt == best_slot &&
                    (hs < best_hs || (hs == best_hs && ns < best_ns)))));
        if (better) begin
          best_len  = LEN_W'(c);
          best_hs   = POS_W'(hs);
          best_ns   = NIDX_W'(ns);
          best_slot = SLOT_W'(slot_cnt);
        end
      end
    end
    // cells beyond the needle length hold no run
    for (j = nl; j < live_span; j++) run_cnt[j] = '0;
    live_span = nl;
    hay_pos = hay_pos + 1'b1;
    if (slots) slot_pos = slot_pos + 1'b1;
  endfunction

  // Form the result of a finish item and start a fresh search
  function automatic lcs_result_t close_search();
    lcs_result_t r;
    bit          found;
    found          = (best_len != 0);
    r.run_len      = best_len;
    r.hay_start    = found ? best_hs : '0;
    r.needle_start = found ? best_ns : '0;
    r.slot         = (found && slot_bytes_q != 0) ? best_slot : '1;
    r.overflow     = hay_overflow;
    restart_search();
    return r;
  endfunction

  // Compare one result with the oldest expectation
  task automatic check_result(input lcs_result_t got);
    lcs_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("with none awaited, raw", longint'(got), 0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.run_len != want.run_len)
      report_mismatch("run_length", got.run_len, want.run_len);
    if (got.hay_start != want.hay_start)
      report_mismatch("hay_offset", got.hay_start, want.hay_start);
    if (got.needle_start != want.needle_start)
      report_mismatch("needle_offset", got.needle_start, want.needle_start);
    if (got.slot != want.slot)
      report_mismatch("slot_index", $signed(got.slot), $signed(want.slot));
    if (got.overflow != want.overflow)
      report_mismatch("hay_overflow", got.overflow, want.overflow);
  endtask

  // Watch the register port and both streams
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_len_q = LEN_W'(32);
      slot_bytes_q = '0;
      for (int j = 0; j < NEEDLE_BYTES; j++) begin
        needle_q[j] = '0;
        run_cnt[j]  = '0;
      end
      live_span = 0;
      restart_search();
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_NEEDLE_LEN: needle_len_q = cfg_wdata_i[LEN_W-1:0];
          CFG_SLOT_BYTES: slot_bytes_q = cfg_wdata_i[SBYT_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tdata[$bits(lcs_result_t)-1:0]);
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          MODE_LOAD:   needle_q[s_axis_tdata[NIDX_W-1:0]] = s_axis_tdata[NIDX_W +: BYTE_W];
          MODE_HAY:    absorb_hay_byte(s_axis_tdata[NIDX_W +: BYTE_W]);
          MODE_FINISH: awaited_results.push_back(close_search());
          default: ;
        endcase
      end
    end
    awaited_o    <= awaited_results.size();
    mismatches_o <= mismatches;
  end

endmodule

// ----- verif/tb_longest_common_substring_run_unit.sv -----
// Testbench top for the longest common substring run unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_longest_common_substring_run_unit;
  import lcsr_pkg::*;

  localparam logic [S_USER_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = NEEDLE_BYTES + 8;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY_SHUT
  } rx_style_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [S_USER_W-1:0]   s_axis_tuser  = MODE_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  int                results_awaited;
  int                check_failures;
  logic [BYTE_W-1:0] needle_mirror [NEEDLE_BYTES];
  int                items_sent      = 0;
  int                burst_left      = 0;
  int                gap_ceiling     = 3;
  int                cycle_count     = 0;
  logic [7:0]        rx_tick         = '0;
  rx_style_e         rx_style        = RX_OPEN;

  longest_common_substring_run_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lcsr_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .awaited_o     (results_awaited),
    .mismatches_o  (check_failures)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result stream in stretches of changing character
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick[5:0] == '0) rx_style <= rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:        m_axis_tready <= 1'b1;
      RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
      RX_ONE_IN_FOUR: m_axis_tready <= (rx_tick[1:0] == 2'b00);
      default:        m_axis_tready <= (rx_tick[3:0] > 4'd10);
    endcase
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold valid over bursts, drop it for a random gap in between
  task automatic pace_sender();
    int gap;
    if (gap_ceiling == 0) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = $urandom_range(1, gap_ceiling);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [S_USER_W-1:0] kind, input logic [NIDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(S_DATA_W - NIDX_W - BYTE_W){1'b0}}, value, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == MODE_LOAD) needle_mirror[idx] = value;
    if (kind != MODE_UNUSED) items_sent++;
    pace_sender();
  endtask

  // Stream a stretch of the needle as haystack, clipped at its end
  task automatic send_needle_stretch(input int first, input int count);
    for (int k = 0; k < count && first + k < NEEDLE_BYTES; k++)
      send_item(MODE_HAY, NIDX_W'($urandom), needle_mirror[first + k]);
  endtask

  // Pause until every result is in and the cell row has drained
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_awaited != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Bytes from a small alphabet so that matches are common
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      3:       return 8'hA5;
      4:       return needle_mirror[$urandom_range(0, NEEDLE_BYTES - 1)];
      5:       return BYTE_W'($urandom);
      default: return needle_mirror[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_needle_len();
    case ($urandom_range(0, 11))
      0:       return CFG_DATA_W'(NEEDLE_BYTES);
      1:       return '0;
      2:       return CFG_DATA_W'(127);
      3:       return CFG_DATA_W'($urandom_range(NEEDLE_BYTES + 1, 127));
      4:       return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_slot_bytes();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4:          return CFG_DATA_W'(255);
      5:          return CFG_DATA_W'(1);
      6:          return CFG_DATA_W'($urandom_range(9, 254));
      default:    return CFG_DATA_W'($urandom_range(2, 8));
    endcase
  endfunction

  // One random search: maybe new registers, maybe a few needle writes, a haystack, usually a finish
  task automatic run_random_search();
    int hay_len, n, pick, start_at, stretch;
    if ($urandom_range(0, 2) == 0) begin
      settle_block();
      write_reg(CFG_NEEDLE_LEN, pick_needle_len());
      write_reg(CFG_SLOT_BYTES, pick_slot_bytes());
    end
    gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    repeat (n) send_item(MODE_LOAD, NIDX_W'($urandom), pick_byte());
    hay_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 30);
    n = 0;
    while (n < hay_len) begin
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        // rewrite the needle while the search runs
        send_item(MODE_LOAD, NIDX_W'($urandom), pick_byte());
      end else if (pick == 1) begin
        send_item(MODE_UNUSED, NIDX_W'($urandom), BYTE_W'($urandom));
      end else if (pick < 16) begin
        start_at = $urandom_range(0, NEEDLE_BYTES - 1);
        stretch  = $urandom_range(1, 12);
        if (stretch > NEEDLE_BYTES - start_at) stretch = NEEDLE_BYTES - start_at;
        if (stretch > hay_len - n) stretch = hay_len - n;
        send_needle_stretch(start_at, stretch);
        n += stretch;
      end else begin
        send_item(MODE_HAY, NIDX_W'($urandom), pick_byte());
        n++;
      end
    end
    // leave some searches open across a register change
    if ($urandom_range(0, 9) != 0) send_item(MODE_FINISH, NIDX_W'($urandom), BYTE_W'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // distinct needle bytes so each directed search has a single answer
    for (int i = 0; i < NEEDLE_BYTES; i++)
      send_item(MODE_LOAD, NIDX_W'(i), BYTE_W'(i * 5 + 3));

    // reset registers: needle length 32, no slots
    send_item(MODE_FINISH, '0, '0);
    send_needle_stretch(4, 5);
    send_item(MODE_HAY, '1, 8'hFF);
    send_item(MODE_FINISH, '1, 8'hFF);
    send_item(MODE_UNUSED, '1, 8'hFF);
    // equal runs: the earliest haystack start wins
    send_needle_stretch(10, 2);
    send_item(MODE_HAY, '0, 8'h00);
    send_needle_stretch(10, 2);
    // run cut at the needle length
    send_needle_stretch(30, 4);
    send_item(MODE_FINISH, '0, '0);

    // zero needle length: nothing matches
    settle_block();
    write_reg(CFG_NEEDLE_LEN, '0);
    write_reg(CFG_SLOT_BYTES, CFG_DATA_W'(255));
    send_needle_stretch(0, 3);
    send_item(MODE_FINISH, '0, '0);

    // oversized needle length, runs cut at slot boundaries
    settle_block();
    write_reg(CFG_NEEDLE_LEN, CFG_DATA_W'(127));
    write_reg(CFG_SLOT_BYTES, CFG_DATA_W'(2));
    send_needle_stretch(58, 6);
    send_item(MODE_FINISH, '0, '0);

    // slot width changed in the middle of a search
    settle_block();
    write_reg(CFG_SLOT_BYTES, CFG_DATA_W'(1));
    send_needle_stretch(20, 2);
    settle_block();
    write_reg(CFG_SLOT_BYTES, '0);
    send_needle_stretch(22, 2);
    send_item(MODE_FINISH, '0, '0);

    // needle rewritten in the middle of a search
    send_needle_stretch(0, 2);
    send_item(MODE_LOAD, NIDX_W'(2), 8'hFF);
    send_item(MODE_HAY, '0, 8'hFF);
    send_item(MODE_FINISH, '0, '0);
    settle_block();

    while (items_sent < RANDOM_ITEMS)
      run_random_search();

    settle_block();
    if (check_failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lcsr_pkg.sv
hw/rtl/lcsr_cell.sv
hw/rtl/lcsr_best.sv
hw/rtl/longest_common_substring_run_unit.sv
verif/lcsr_result_checker.sv
verif/tb_longest_common_substring_run_unit.sv
